### hdl/csia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csia_pkg: shared types and constants for the circular slot id allocator
// Table geometry, action codes, memory port bundles and priority encoders.
// ----------------------------------------------------------------------------
package csia_pkg;

	// Table geometry; the slot id port width covers the slot count
	localparam int SLOTS     = 1024;
	localparam int QUEUES    = 256;
	localparam int SLOT_W    = 10;
	localparam int QUEUE_W   = 8;
	localparam int TAG_W     = 32;
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int ROWS      = SLOTS / WORD_BITS;
	localparam int ROW_W     = $clog2(ROWS);

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [BIT_W-1:0]     bit_t;
	typedef logic [ROWS-1:0]      row_vec_t;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_PLACE   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_LOOKUP  = 2'd3
	} action_t;

	// Tags kept per slot
	typedef struct packed {
		logic [TAG_W-1:0]   owner_tag;
		logic [TAG_W-1:0]   task_tag;
		logic [QUEUE_W-1:0] queue_tag;
	} tag_t;

	// Write port of the occupancy row memory
	typedef struct packed {
		logic  en;
		row_t  row;
		word_t word;
	} occ_wr_t;

	// Write port of the tag memory
	typedef struct packed {
		logic  en;
		slot_t addr;
		tag_t  data;
	} tag_wr_t;

	// Index of the lowest set bit of a row word
	function automatic bit_t first_bit(input word_t v);
		bit_t idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = bit_t'(i);
		end
		return idx;
	endfunction

	// Index of the lowest set bit of a row vector
	function automatic row_t first_row(input row_vec_t v);
		row_t idx;
		idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (v[i]) idx = row_t'(i);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### hdl/csia_tag_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csia_tag_mem: per-slot tag memory
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module csia_tag_mem (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire csia_pkg::slot_t  rd_addr,
	input  wire csia_pkg::tag_wr_t wr,
	output csia_pkg::tag_t        rd_data
);

	csia_pkg::tag_t tag_mem [csia_pkg::SLOTS];
	csia_pkg::tag_t rd_data_q;

	// Write and read the tag array
	always_ff @(posedge clk) begin
		if (wr.en) tag_mem[wr.addr] <= wr.data;
		if (rd_en) rd_data_q <= tag_mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

### hdl/csia_occ_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csia_occ_store: occupancy bitmap held as rows of slot bits
// Row memory with two registered read ports and one write port, a valid bit
// per row so reset empties the table at once, and a full flag per row.
// ----------------------------------------------------------------------------
module csia_occ_store (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire csia_pkg::row_t     rd_row_a,
	input  wire csia_pkg::row_t     rd_row_b,
	input  wire csia_pkg::occ_wr_t  wr,
	output csia_pkg::word_t         word_a,
	output csia_pkg::word_t         word_b,
	output csia_pkg::row_vec_t      full
);

	csia_pkg::word_t    occ_mem [csia_pkg::ROWS];
	csia_pkg::word_t    data_a_q;
	csia_pkg::word_t    data_b_q;
	csia_pkg::row_vec_t rv_q;
	csia_pkg::row_vec_t full_q;
	logic               va_q;
	logic               vb_q;
	logic               za_q;
	logic               zb_q;

	// Row array: write back and read both ports
	always_ff @(posedge clk) begin
		if (wr.en) occ_mem[wr.row] <= wr.word;
		if (rd_en) begin
			data_a_q <= occ_mem[rd_row_a];
			data_b_q <= occ_mem[rd_row_b];
		end
	end

	// Row valid and full flags, plus the read-side qualifiers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q   <= '0;
			full_q <= '0;
			va_q   <= 1'b0;
			vb_q   <= 1'b0;
			za_q   <= 1'b0;
			zb_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				rv_q[wr.row]   <= 1'b1;
				full_q[wr.row] <= &wr.word;
			end
			if (rd_en) begin
				va_q <= rv_q[rd_row_a];
				vb_q <= rv_q[rd_row_b];
				za_q <= (rd_row_a == '0);
				zb_q <= (rd_row_b == '0);
			end
		end
	end

	// Unwritten rows read empty; slot zero always reads as taken
	assign word_a = (va_q ? data_a_q : '0) | (za_q ? csia_pkg::word_t'(1) : '0);
	assign word_b = (vb_q ? data_b_q : '0) | (zb_q ? csia_pkg::word_t'(1) : '0);
	assign full   = full_q;

endmodule
`default_nettype wire

### hdl/circular_slot_id_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_slot_id_allocator_top: slot table with next-fit circular allocation
// Allocate, place, release and look up task slots by command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. In the accept cycle
// the occupancy rows and the tag memory are read; in the next cycle (busy
// high) the free slot is picked and any write-back is done, and the result is
// registered onto the output ports with done high in the cycle after that,
// while the next command can already be taken. No new command is taken while
// busy is high; the read-then-write of the occupancy memory sets this.
// The receiver cannot stall: done is a one-cycle strobe. Allocate searches
// the upper part of the current row, then the first non-full row in circular
// order, then the lower part of the current row. The table is empty right
// after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_slot_id_allocator_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     action,
	input  wire logic [csia_pkg::SLOT_W-1:0]    slot_id,
	input  wire logic [csia_pkg::TAG_W-1:0]     owner_tag,
	input  wire logic [csia_pkg::TAG_W-1:0]     task_tag,
	input  wire logic [csia_pkg::QUEUE_W-1:0]   queue_tag,
	output logic                                done,
	output logic                                ok,
	output logic [csia_pkg::SLOT_W-1:0]         slot_out,
	output logic [csia_pkg::TAG_W-1:0]          owner_out,
	output logic [csia_pkg::TAG_W-1:0]          task_out,
	output logic [csia_pkg::QUEUE_W-1:0]        queue_out
);

	logic                accept;
	logic                busy_q;
	csia_pkg::slot_t     last_q;

	// Accept-cycle search state
	csia_pkg::slot_t     base_now;
	csia_pkg::row_t      r0_now;
	csia_pkg::row_t      k_now;
	csia_pkg::row_t      scan_row;
	csia_pkg::row_vec_t  avail;
	csia_pkg::row_t      rd_row_a;

	// Stage 1 word
	csia_pkg::action_t   action_s1;
	csia_pkg::slot_t     slot_s1;
	csia_pkg::tag_t      tag_s1;
	csia_pkg::slot_t     base_s1;
	csia_pkg::row_t      krow_s1;
	logic                kfound_s1;

	// Memory ports
	csia_pkg::word_t     word_a;
	csia_pkg::word_t     word_b;
	csia_pkg::row_vec_t  full;
	csia_pkg::tag_t      tag_rd;
	csia_pkg::occ_wr_t   occ_wr;
	csia_pkg::tag_wr_t   tag_wr;

	// Stage 1 decisions
	logic                res_ok;
	csia_pkg::slot_t     res_slot;
	csia_pkg::tag_t      res_tag;
	logic                alloc_hit;
	csia_pkg::row_t      pick_row;
	csia_pkg::bit_t      pick_bit;
	csia_pkg::word_t     pick_word;

	// Result register
	logic                done_q;
	logic                ok_q;
	csia_pkg::slot_t     slot_out_q;
	csia_pkg::tag_t      tag_out_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Find the first non-full row after the starting row, circularly
	always_comb begin
		base_now = last_q + csia_pkg::slot_t'(1);
		r0_now   = base_now[csia_pkg::SLOT_W-1:csia_pkg::BIT_W];
		avail    = '0;
		scan_row = '0;
		for (int j = 0; j < csia_pkg::ROWS - 1; j++) begin
			scan_row = r0_now + csia_pkg::row_t'(j + 1);
			avail[j] = !full[scan_row];
		end
		k_now    = r0_now + csia_pkg::first_row(avail) + csia_pkg::row_t'(1);
		rd_row_a = (csia_pkg::action_t'(action) == csia_pkg::ACT_ALLOC) ? r0_now :
			slot_id[csia_pkg::SLOT_W-1:csia_pkg::BIT_W];
	end

	csia_occ_store u_occ (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_row_a (rd_row_a),
		.rd_row_b (k_now),
		.wr       (occ_wr),
		.word_a   (word_a),
		.word_b   (word_b),
		.full     (full)
	);

	csia_tag_mem u_tag (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot_id),
		.wr      (tag_wr),
		.rd_data (tag_rd)
	);

	// Capture the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= csia_pkg::action_t'(action);
			slot_s1   <= slot_id;
			tag_s1    <= '{owner_tag: owner_tag, task_tag: task_tag, queue_tag: queue_tag};
			base_s1   <= base_now;
			krow_s1   <= k_now;
			kfound_s1 <= |avail;
		end
	end

	// Pick the slot, build write-backs and the result
	always_comb begin
		logic            queue_ok;
		logic            sid_ok;
		csia_pkg::row_t  r0;
		csia_pkg::bit_t  b0;
		csia_pkg::word_t hi_mask;
		csia_pkg::word_t free0;
		csia_pkg::word_t hi;
		csia_pkg::word_t lo;
		csia_pkg::word_t sbit;

		queue_ok = 32'(tag_s1.queue_tag) < csia_pkg::QUEUES;
		sid_ok   = (slot_s1 != '0) && (32'(slot_s1) < csia_pkg::SLOTS);
		r0       = base_s1[csia_pkg::SLOT_W-1:csia_pkg::BIT_W];
		b0       = base_s1[csia_pkg::BIT_W-1:0];
		hi_mask  = {csia_pkg::WORD_BITS{1'b1}} << b0;
		free0    = ~word_a;
		hi       = free0 & hi_mask;
		lo       = free0 & ~hi_mask;
		sbit     = csia_pkg::word_t'(1) << slot_s1[csia_pkg::BIT_W-1:0];

		// Search order: upper part of start row, other rows, lower part
		alloc_hit = 1'b0;
		pick_row  = r0;
		pick_bit  = '0;
		pick_word = word_a;
		priority if (|hi) begin
			alloc_hit = 1'b1;
			pick_bit  = csia_pkg::first_bit(hi);
		end else if (kfound_s1) begin
			alloc_hit = 1'b1;
			pick_row  = krow_s1;
			pick_bit  = csia_pkg::first_bit(~word_b);
			pick_word = word_b;
		end else if (|lo) begin
			alloc_hit = 1'b1;
			pick_bit  = csia_pkg::first_bit(lo);
		end else begin
			alloc_hit = 1'b0;
		end

		res_ok   = 1'b0;
		res_slot = '0;
		res_tag  = '0;
		occ_wr   = '{en: 1'b0, row: slot_s1[csia_pkg::SLOT_W-1:csia_pkg::BIT_W], word: word_a};
		tag_wr   = '{en: 1'b0, addr: slot_s1, data: tag_s1};

		if (busy_q) begin
			unique case (action_s1)
				csia_pkg::ACT_ALLOC: begin
					if (queue_ok && alloc_hit) begin
						res_ok      = 1'b1;
						res_slot    = {pick_row, pick_bit};
						occ_wr.en   = 1'b1;
						occ_wr.row  = pick_row;
						occ_wr.word = pick_word | (csia_pkg::word_t'(1) << pick_bit);
						tag_wr.en   = 1'b1;
						tag_wr.addr = {pick_row, pick_bit};
					end
				end
				csia_pkg::ACT_PLACE: begin
					if (sid_ok && queue_ok) begin
						res_ok      = 1'b1;
						res_slot    = slot_s1;
						occ_wr.en   = 1'b1;
						occ_wr.word = word_a | sbit;
						tag_wr.en   = 1'b1;
					end
				end
				csia_pkg::ACT_RELEASE: begin
					if (sid_ok && ((word_a & sbit) != '0)) begin
						res_ok      = 1'b1;
						res_slot    = slot_s1;
						res_tag     = tag_rd;
						occ_wr.en   = 1'b1;
						occ_wr.word = word_a & ~sbit;
					end
				end
				csia_pkg::ACT_LOOKUP: begin
					if (sid_ok && ((word_a & sbit) != '0)) begin
						res_ok   = 1'b1;
						res_slot = slot_s1;
						res_tag  = tag_rd;
					end
				end
				default: begin
					res_ok = 1'b0;
				end
			endcase
		end
	end

	// Control: busy for one cycle per command, last slot, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			last_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q && res_ok && (action_s1 == csia_pkg::ACT_ALLOC)) begin
				last_q <= res_slot;
			end
		end
	end

	// Hold the result word for its strobe cycle
	always_ff @(posedge clk) begin
		if (busy_q) begin
			ok_q       <= res_ok;
			slot_out_q <= res_slot;
			tag_out_q  <= res_tag;
		end
	end

	assign done      = done_q;
	assign ok        = ok_q;
	assign slot_out  = slot_out_q;
	assign owner_out = tag_out_q.owner_tag;
	assign task_out  = tag_out_q.task_tag;
	assign queue_out = tag_out_q.queue_tag;

	// A command occupies exactly one busy cycle
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held for more than one cycle");

	// Every result follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a command");

	// Slot zero is never reported as a success
	a_no_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ok_q) |-> (slot_out_q != '0))
		else $error("slot zero handed out");

	// A successful allocate becomes the new search origin
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ok_q && (action_s1 == csia_pkg::ACT_ALLOC)) |-> (last_q == slot_out_q))
		else $error("last slot not updated by allocate");

	// Memories are written only while a command is in work
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_wr.en || tag_wr.en) |-> busy_q)
		else $error("memory write outside a command");

endmodule
`default_nettype wire

### tb/circular_slot_id_allocator_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_slot_id_allocator_top_test: self-checking bench for the slot table
// Drives allocate, place, release and look up commands with random gaps.
// A short directed table comes first, then random mixes and a fill of the
// whole table. Every result word is checked against the typed expectation of
// the directed table or a behavioral copy of the slot table kept in the bench.
// ----------------------------------------------------------------------------
module circular_slot_id_allocator_top_test;
	import csia_pkg::*;

	typedef struct packed {
		logic              ok;
		slot_t             slot;
		logic [TAG_W-1:0]  owner;
		logic [TAG_W-1:0]  job;
		logic [QUEUE_W-1:0] qnum;
	} slot_reply_t;

	typedef struct packed {
		action_t            act;
		slot_t              sid;
		logic [TAG_W-1:0]   own;
		logic [TAG_W-1:0]   tsk;
		logic [QUEUE_W-1:0] que;
		logic               typed;
		slot_reply_t        want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           action;
	logic [SLOT_W-1:0]    slot_id;
	logic [TAG_W-1:0]     owner_tag;
	logic [TAG_W-1:0]     task_tag;
	logic [QUEUE_W-1:0]   queue_tag;
	logic                 done;
	logic                 ok;
	logic [SLOT_W-1:0]    slot_out;
	logic [TAG_W-1:0]     owner_out;
	logic [TAG_W-1:0]     task_out;
	logic [QUEUE_W-1:0]   queue_out;

	// Bench copy of the slot table
	bit                   slot_used [SLOTS];
	logic [TAG_W-1:0]     owner_mem [SLOTS];
	logic [TAG_W-1:0]     job_mem   [SLOTS];
	logic [QUEUE_W-1:0]   qnum_mem  [SLOTS];
	int                   last_given;
	int                   used_count;

	slot_reply_t          pending_replies [$];
	slot_reply_t          head_reply;
	plan_row_t            plan [$];
	int                   mismatches;
	int                   calm_left;

	circular_slot_id_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.slot_id   (slot_id),
		.owner_tag (owner_tag),
		.task_tag  (task_tag),
		.queue_tag (queue_tag),
		.done      (done),
		.ok        (ok),
		.slot_out  (slot_out),
		.owner_out (owner_out),
		.task_out  (task_out),
		.queue_out (queue_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Fill one slot of the bench table
	function automatic void store_slot(int s, logic [TAG_W-1:0] own, logic [TAG_W-1:0] tsk,
			logic [QUEUE_W-1:0] que);
		if (!slot_used[s]) used_count++;
		slot_used[s] = 1'b1;
		owner_mem[s] = own;
		job_mem[s]   = tsk;
		qnum_mem[s]  = que;
	endfunction

	// Apply one command to the bench table and return its result word
	function automatic slot_reply_t apply_slot_cmd(action_t act, slot_t sid,
			logic [TAG_W-1:0] own, logic [TAG_W-1:0] tsk, logic [QUEUE_W-1:0] que);
		slot_reply_t r;
		int c;
		r = '0;
		if (act == ACT_ALLOC) begin
			if (int'(que) < QUEUES) begin
				// next-fit search from the slot after the last one handed out
				for (int i = 1; i <= SLOTS && !r.ok; i++) begin
					c = (last_given + i) % SLOTS;
					if (c != 0 && !slot_used[c]) begin
						store_slot(c, own, tsk, que);
						last_given = c;
						r.ok = 1'b1;
						r.slot = slot_t'(c);
					end
				end
			end
		end else if (sid != '0 && int'(sid) < SLOTS) begin
			if (act == ACT_PLACE) begin
				if (int'(que) < QUEUES) begin
					store_slot(int'(sid), own, tsk, que);
					r.ok = 1'b1;
					r.slot = sid;
				end
			end else if (slot_used[sid]) begin
				r.ok = 1'b1;
				r.slot = sid;
				r.owner = owner_mem[sid];
				r.job = job_mem[sid];
				r.qnum = qnum_mem[sid];
				if (act == ACT_RELEASE) begin
					slot_used[sid] = 1'b0;
					used_count--;
				end
			end
		end
		return r;
	endfunction

	// Pick an occupied slot near a random point, or the point itself if none is
	function automatic slot_t pick_used_slot();
		int base;
		int c;
		slot_t pick;
		bit hit;
		base = $urandom_range(1, SLOTS - 1);
		pick = slot_t'(base);
		hit = 1'b0;
		for (int i = 0; i < SLOTS && !hit; i++) begin
			c = (base + i) % SLOTS;
			if (c != 0 && slot_used[c]) begin
				pick = slot_t'(c);
				hit = 1'b1;
			end
		end
		return pick;
	endfunction

	function automatic plan_row_t mk_row(action_t a, slot_t s, logic [TAG_W-1:0] o,
			logic [TAG_W-1:0] t, logic [QUEUE_W-1:0] q, logic typed, logic w_ok,
			slot_t w_slot, logic [TAG_W-1:0] w_o, logic [TAG_W-1:0] w_t,
			logic [QUEUE_W-1:0] w_q);
		plan_row_t row;
		row.act = a;
		row.sid = s;
		row.own = o;
		row.tsk = t;
		row.que = q;
		row.typed = typed;
		row.want = '{w_ok, w_slot, w_o, w_t, w_q};
		return row;
	endfunction

	// Present one command word, wait for acceptance, then idle for a random gap
	task automatic send_cmd(action_t act, slot_t sid, logic [TAG_W-1:0] own,
			logic [TAG_W-1:0] tsk, logic [QUEUE_W-1:0] que, logic typed, slot_reply_t want);
		slot_reply_t got;
		int gap;
		@(negedge clk);
		start     <= 1'b1;
		action    <= act;
		slot_id   <= sid;
		owner_tag <= own;
		task_tag  <= tsk;
		queue_tag <= que;
		@(posedge clk);
		while (busy) @(posedge clk);
		got = apply_slot_cmd(act, sid, own, tsk, que);
		pending_replies.push_back(typed ? want : got);
		if (calm_left > 0) begin
			gap = 0;
			calm_left--;
		end else begin
			gap = $urandom_range(0, 9);
			if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Random command mix, mostly aimed at occupied slots
	task automatic run_mix(int count, int alloc_pct);
		action_t act;
		slot_t sid;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 99) < alloc_pct) act = ACT_ALLOC;
			else if (pick < 2) act = ACT_PLACE;
			else if (pick < 6) act = ACT_RELEASE;
			else act = ACT_LOOKUP;
			pick = $urandom_range(0, 9);
			if (act == ACT_ALLOC || pick == 1) sid = slot_t'($urandom_range(0, SLOTS - 1));
			else if (pick == 0) sid = '0;
			else if (pick == 2) sid = slot_t'(SLOTS - 1);
			else sid = pick_used_slot();
			send_cmd(act, sid, $urandom, $urandom, QUEUE_W'($urandom_range(0, QUEUES - 1)),
				1'b0, '0);
		end
	endtask

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("result word with no command pending: slot_out %0d", slot_out);
				mismatches++;
			end else begin
				head_reply = pending_replies.pop_front();
				if (ok !== head_reply.ok) begin
					$error("ok: expected %0d, actual %0d", head_reply.ok, ok);
					mismatches++;
				end
				if (slot_out !== head_reply.slot) begin
					$error("slot_out: expected %0d, actual %0d", head_reply.slot, slot_out);
					mismatches++;
				end
				if (owner_out !== head_reply.owner) begin
					$error("owner_out: expected %h, actual %h", head_reply.owner, owner_out);
					mismatches++;
				end
				if (task_out !== head_reply.job) begin
					$error("task_out: expected %h, actual %h", head_reply.job, task_out);
					mismatches++;
				end
				if (queue_out !== head_reply.qnum) begin
					$error("queue_out: expected %h, actual %h", head_reply.qnum, queue_out);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = '0;
		slot_id    = '0;
		owner_tag  = '0;
		task_tag   = '0;
		queue_tag  = '0;
		mismatches = 0;
		calm_left  = 0;
		last_given = 0;
		used_count = 0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_used[s] = 1'b0;
			owner_mem[s] = '0;
			job_mem[s]   = '0;
			qnum_mem[s]  = '0;
		end

		// Directed table: typed results only where they are obvious
		plan.push_back(mk_row(ACT_LOOKUP, 10'd5, 32'h1, 32'h2, 8'h3,
			1'b1, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_RELEASE, 10'd0, 32'h0, 32'h0, 8'h0,
			1'b1, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_ALLOC, 10'h3ff, 32'hffffffff, 32'h0, 8'hff,
			1'b1, 1'b1, 10'd1, '0, '0, '0));
		plan.push_back(mk_row(ACT_ALLOC, 10'd0, 32'h0, 32'hffffffff, 8'h00,
			1'b1, 1'b1, 10'd2, '0, '0, '0));
		plan.push_back(mk_row(ACT_LOOKUP, 10'd1, 32'h0, 32'h0, 8'h0,
			1'b1, 1'b1, 10'd1, 32'hffffffff, 32'h0, 8'hff));
		plan.push_back(mk_row(ACT_PLACE, 10'd1023, 32'ha5a5a5a5, 32'h5a5a5a5a, 8'h80,
			1'b1, 1'b1, 10'd1023, '0, '0, '0));
		plan.push_back(mk_row(ACT_PLACE, 10'd0, 32'h11, 32'h22, 8'h33,
			1'b1, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_LOOKUP, 10'd0, 32'h0, 32'h0, 8'h0,
			1'b1, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_PLACE, 10'd1, 32'h12345678, 32'h9abcdef0, 8'h07,
			1'b1, 1'b1, 10'd1, '0, '0, '0));
		plan.push_back(mk_row(ACT_LOOKUP, 10'd1, 32'h0, 32'h0, 8'h0,
			1'b0, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_RELEASE, 10'd2, 32'h0, 32'h0, 8'h0,
			1'b1, 1'b1, 10'd2, 32'h0, 32'hffffffff, 8'h00));
		plan.push_back(mk_row(ACT_RELEASE, 10'd2, 32'h0, 32'h0, 8'h0,
			1'b1, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_LOOKUP, 10'd2, 32'h0, 32'h0, 8'h0,
			1'b1, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_ALLOC, 10'd2, 32'hdeadbeef, 32'h0badf00d, 8'h42,
			1'b1, 1'b1, 10'd3, '0, '0, '0));
		plan.push_back(mk_row(ACT_LOOKUP, 10'd1023, 32'h0, 32'h0, 8'h0,
			1'b0, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_RELEASE, 10'd1023, 32'h0, 32'h0, 8'h0,
			1'b0, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_PLACE, 10'd512, 32'h80000001, 32'h7ffffffe, 8'h81,
			1'b0, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_ALLOC, 10'd0, 32'h55555555, 32'haaaaaaaa, 8'h55,
			1'b0, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_RELEASE, 10'd1, 32'h0, 32'h0, 8'h0,
			1'b0, 1'b0, '0, '0, '0, '0));
		plan.push_back(mk_row(ACT_ALLOC, 10'd0, 32'h0f0f0f0f, 32'hf0f0f0f0, 8'h0f,
			1'b0, 1'b0, '0, '0, '0, '0));

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			send_cmd(plan[i].act, plan[i].sid, plan[i].own, plan[i].tsk, plan[i].que,
				plan[i].typed, plan[i].want);

		// Random mix at low occupancy
		run_mix(500, 35);

		// Fill the table, then hit it while full
		while (used_count < SLOTS - 1)
			send_cmd(ACT_ALLOC, slot_t'($urandom_range(0, SLOTS - 1)), $urandom, $urandom,
				QUEUE_W'($urandom_range(0, QUEUES - 1)), 1'b0, '0);
		repeat (8)
			send_cmd(ACT_ALLOC, slot_t'($urandom_range(0, SLOTS - 1)), $urandom, $urandom,
				QUEUE_W'($urandom_range(0, QUEUES - 1)), 1'b0, '0);

		// Release and reallocate, starting from the full table
		run_mix(300, 40);

		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hang guard
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
